// ===== hdl/hlr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlr_pkg
// Types and constants shared by the Huber loss reduction block.
// ----------------------------------------------------------------------------
package hlr_pkg;

  localparam int DATA_W  = 16;
  localparam int AD_W    = 17;   // |pred - target| needs one bit more
  localparam int PROD_W  = 34;
  localparam int DSQ_W   = 32;
  localparam int LOSS_W  = 34;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = 6;

  // configuration register indexes
  localparam logic CFG_DELTA       = 1'b0;
  localparam logic CFG_REDUCE_MEAN = 1'b1;

  localparam logic [DATA_W-1:0] DELTA_RESET       = 16'd256;
  localparam logic              REDUCE_MEAN_RESET = 1'b1;

  // one classified element travelling from front to back
  typedef struct packed {
    logic [AD_W-1:0] diff_mag;
    logic            lin;
    logic            last;
  } hlr_item_t;

  typedef enum logic [1:0] {
    RES_IDLE,
    RES_DIV,
    RES_HOLD
  } res_state_t;

endpackage

// ===== hdl/hlr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlr_front
// Accepts sample pairs, forms |pred - target| and picks the loss branch.
// ----------------------------------------------------------------------------
module hlr_front import hlr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_pred_value,
  input  logic signed [DATA_W-1:0] in_target_value,
  input  logic                     in_last,
  input  logic [DATA_W-1:0]        delta,
  output logic                     item_valid,
  input  logic                     item_ready,
  output hlr_item_t                item
);

  logic            vld_r;
  hlr_item_t       item_r;
  logic [AD_W-1:0] diff;
  logic [AD_W-1:0] diff_mag;

  assign diff     = {in_pred_value[DATA_W-1], in_pred_value}
                  - {in_target_value[DATA_W-1], in_target_value};
  assign diff_mag = diff[AD_W-1] ? (~diff + 1'b1) : diff;

  assign in_ready   = !vld_r || item_ready;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.diff_mag <= diff_mag;
      item_r.lin      <= diff_mag > {1'b0, delta};
      item_r.last     <= in_last;
    end
  end

endmodule

// ===== hdl/hlr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlr_queue
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module hlr_queue import hlr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  hlr_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output hlr_item_t pop_item
);

  hlr_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

// ===== hdl/hlr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlr_back
// Element loss, batch accumulation and the result unit with a serial divider.
// ----------------------------------------------------------------------------
module hlr_back import hlr_pkg::*; #(
  parameter int MAX_ELEMENTS = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              item_ready,
  input  hlr_item_t         item,
  input  logic [DATA_W-1:0] delta,
  input  logic              reduce_mean,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SUM_W-1:0]  out_loss_total,
  output logic [CNT_W-1:0]  out_element_count,
  output logic              out_overflow
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  // multiply stage
  logic              m_vld_r;
  logic              m_lin_r;
  logic              m_last_r;
  logic [PROD_W-1:0] prod_r;
  logic [DSQ_W-1:0]  dsq_r;
  logic [AD_W-1:0]   mul_a;

  // accumulate stage
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              drop_r;
  logic [PROD_W:0]   twice_lin;
  logic [LOSS_W-1:0] loss;
  logic              keep;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              drop_nxt;
  logic              acc_take;
  logic              close_batch;
  logic              do_div;

  // result unit
  res_state_t           state_r;
  res_state_t           state_nxt;
  logic [SUM_W-1:0]     quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     den_r;
  logic [CNT_W-1:0]     ecnt_r;
  logic                 ovf_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_dif;
  logic                 rem_ge;

  // ---- multiply ----
  assign mul_a      = item.lin ? {1'b0, delta} : item.diff_mag;
  assign acc_take   = m_vld_r && !(m_last_r && state_r != RES_IDLE);
  assign item_ready = !m_vld_r || acc_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (item_ready) begin
      m_vld_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    dsq_r <= delta * delta;
    if (item_valid && item_ready) begin
      prod_r   <= mul_a * item.diff_mag;
      m_lin_r  <= item.lin;
      m_last_r <= item.last;
    end
  end

  // ---- accumulate ----
  // linear branch: (2*delta*|d| - delta^2) / 2, truncated
  assign twice_lin = {prod_r, 1'b0} - {3'b000, dsq_r};
  assign loss      = m_lin_r ? twice_lin[PROD_W:1] : {1'b0, prod_r[PROD_W-1:1]};
  assign keep      = cnt_r < MAX_CNT;
  assign sum_nxt   = keep ? sum_r + {{(SUM_W-LOSS_W){1'b0}}, loss} : sum_r;
  assign cnt_nxt   = keep ? cnt_r + 1'b1 : cnt_r;
  assign drop_nxt  = drop_r || !keep;

  assign close_batch = acc_take && m_last_r;
  assign do_div      = reduce_mean && (cnt_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else if (acc_take) begin
      if (m_last_r) begin
        sum_r  <= '0;
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end else begin
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

  // ---- result unit: restoring divide, one quotient bit per cycle ----
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign rem_ge  = rem_sh >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      RES_IDLE: begin
        if (close_batch) begin
          state_nxt = do_div ? RES_DIV : RES_HOLD;
        end
      end
      RES_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = RES_HOLD;
        end
      end
      RES_HOLD: begin
        if (out_ready) begin
          state_nxt = RES_IDLE;
        end
      end
      default: state_nxt = RES_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RES_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == RES_IDLE && close_batch) begin
      // mean of an empty batch reads as zero
      quo_r     <= (reduce_mean && !do_div) ? '0 : sum_nxt;
      rem_r     <= '0;
      den_r     <= cnt_nxt;
      ecnt_r    <= cnt_nxt;
      ovf_r     <= drop_nxt;
      div_cnt_r <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (state_r == RES_DIV) begin
      rem_r     <= rem_ge ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r     <= {quo_r[SUM_W-2:0], rem_ge};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_comb begin
    out_valid         = state_r == RES_HOLD;
    out_loss_total    = quo_r;
    out_element_count = ecnt_r;
    out_overflow      = ovf_r;
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("element count past batch limit");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RES_DIV && div_cnt_r == '0) |=> state_r == RES_HOLD)
    else $error("divider did not hand over its quotient");

  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    close_batch |=> (cnt_r == '0 && sum_r == '0 && !drop_r))
    else $error("batch state not cleared after last word");

endmodule

// ===== hdl/huber_loss_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huber_loss_reduce
// Huber loss over a stream of Q8.8 pairs, summed or averaged per batch.
// Result: a sum goes straight to the output register; a mean first passes
//   through the bit-serial divider.
// Throughput: one pair per cycle; a last word waits in the back end until
//   the previous batch result has been taken.
// Reset: synchronous, active low; clears queue, batch sums and the result
//   unit, and sets delta to 1.0 and mean reduction on.
// ----------------------------------------------------------------------------
module huber_loss_reduce import hlr_pkg::*; #(
  parameter int MAX_ELEMENTS = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_pred_value,
  input  logic signed [DATA_W-1:0] in_target_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SUM_W-1:0]         out_loss_total,
  output logic [CNT_W-1:0]         out_element_count,
  output logic                     out_overflow,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  logic [DATA_W-1:0] delta_r;
  logic              reduce_mean_r;

  logic      f_valid;
  logic      f_ready;
  hlr_item_t f_item;
  logic      q_valid;
  logic      q_ready;
  hlr_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r       <= DELTA_RESET;
      reduce_mean_r <= REDUCE_MEAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELTA:       delta_r       <= cfg_data;
        CFG_REDUCE_MEAN: reduce_mean_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hlr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pred_value   (in_pred_value),
    .in_target_value (in_target_value),
    .in_last         (in_last),
    .delta           (delta_r),
    .item_valid      (f_valid),
    .item_ready      (f_ready),
    .item            (f_item)
  );

  hlr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  hlr_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (q_valid),
    .item_ready        (q_ready),
    .item              (q_item),
    .delta             (delta_r),
    .reduce_mean       (reduce_mean_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_loss_total    (out_loss_total),
    .out_element_count (out_element_count),
    .out_overflow      (out_overflow)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for huber_loss_reduce. A directed table covers reset
// values, field extremes, the branch boundary and zero delta. Random batches
// follow under three idling mixes and a long output hold-off. An in-bench
// batch model predicts each result that the table does not give; results are
// compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import hlr_pkg::*;

  localparam int MAX_ELEMS      = 65536;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 125;

  typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [SUM_W-1:0] loss;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } batch_result_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              cfg_sel;
    logic [DATA_W-1:0] pred;     // register data on a configuration row
    logic [DATA_W-1:0] target;
    logic              last;
    logic              typed;
    batch_result_t     want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_pred_value = '0;
  logic [DATA_W-1:0] in_target_value = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SUM_W-1:0]  out_loss_total;
  logic [CNT_W-1:0]  out_element_count;
  logic              out_overflow;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_DELTA;
  logic [DATA_W-1:0] cfg_data = '0;

  // batch model
  logic [DATA_W-1:0] mdl_delta   = DELTA_RESET;
  logic              mdl_mean    = REDUCE_MEAN_RESET;
  logic [SUM_W-1:0]  mdl_sum     = '0;
  logic [CNT_W-1:0]  mdl_count   = '0;
  logic              mdl_dropped = 1'b0;

  batch_result_t pending_results[$];
  stim_row_t     dir_rows[$];
  batch_result_t head;

  int  errors        = 0;
  int  send_idle_pct = 9;
  int  recv_idle_pct = 83;
  int  hold_left     = 0;
  int  quiet_cycles  = 0;
  bit  hold_req      = 1'b0;
  bit  hold_taken    = 1'b0;

  huber_loss_reduce #(.MAX_ELEMENTS(MAX_ELEMS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pred_value     (in_pred_value),
    .in_target_value   (in_target_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_loss_total    (out_loss_total),
    .out_element_count (out_element_count),
    .out_overflow      (out_overflow),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned huber_elem_loss(logic [DATA_W-1:0] p,
                                                      logic [DATA_W-1:0] t,
                                                      logic [DATA_W-1:0] dl);
    longint          diff;
    longint unsigned mag;
    longint unsigned thr;
    diff = longint'($signed(p)) - longint'($signed(t));
    mag  = (diff < 0) ? -diff : diff;
    thr  = dl;
    if (mag <= thr) return (mag * mag) >> 1;
    return (2 * thr * mag - thr * thr) >> 1;
  endfunction

  // fold one pair into the running batch; close the batch on last
  task automatic fold_pair(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] t,
                           input logic l, output bit closed, output batch_result_t res);
    if (mdl_count < MAX_ELEMS) begin
      mdl_sum   = mdl_sum + SUM_W'(huber_elem_loss(p, t, mdl_delta));
      mdl_count = mdl_count + 1'b1;
    end else begin
      mdl_dropped = 1'b1;
    end
    closed       = l;
    res.loss     = mdl_sum;
    if (mdl_mean) res.loss = (mdl_count != 0) ? mdl_sum / mdl_count : '0;
    res.count    = mdl_count;
    res.overflow = mdl_dropped;
    if (l) begin
      mdl_sum     = '0;
      mdl_count   = '0;
      mdl_dropped = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == CFG_DELTA) mdl_delta = data;
    else mdl_mean = data[0];
  endtask

  task automatic send_pair(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] t,
                           input logic l, input logic typed, input batch_result_t want);
    bit            closed;
    batch_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pred_value   <= p;
    in_target_value <= t;
    in_last         <= l;
    do @(posedge clk); while (!in_ready);
    fold_pair(p, t, l, closed, res);
    if (closed) pending_results.push_back(typed ? want : res);
  endtask

  function automatic void add_pair(logic [DATA_W-1:0] p, logic [DATA_W-1:0] t, logic l);
    stim_row_t r;
    r        = '0;
    r.kind   = ROW_PAIR;
    r.pred   = p;
    r.target = t;
    r.last   = l;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_checked(logic [DATA_W-1:0] p, logic [DATA_W-1:0] t,
                                      logic [SUM_W-1:0] loss, logic [CNT_W-1:0] cnt,
                                      logic ovf);
    stim_row_t r;
    r               = '0;
    r.kind          = ROW_PAIR;
    r.pred          = p;
    r.target        = t;
    r.last          = 1'b1;
    r.typed         = 1'b1;
    r.want.loss     = loss;
    r.want.count    = cnt;
    r.want.overflow = ovf;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic sel, logic [DATA_W-1:0] data);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.cfg_sel = sel;
    r.pred    = data;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [DATA_W-1:0] corner_sample();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  task automatic pick_pair(output logic [DATA_W-1:0] p, output logic [DATA_W-1:0] t);
    case ($urandom_range(3))
      0, 1:    p = 16'($urandom);
      2:       p = corner_sample();
      default: p = 16'($urandom_range(2047)) - 16'd1024;
    endcase
    // keep many differences near the threshold
    case ($urandom_range(2))
      0:       t = 16'($urandom);
      1:       t = p - 16'($urandom_range(1023)) + 16'd512;
      default: t = corner_sample();
    endcase
  endtask

  // receiver: random back-pressure, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unsolicited result word", out_loss_total, 0);
      end else begin
        head = pending_results.pop_front();
        if (out_loss_total !== head.loss)
          flag_mismatch("loss_total", out_loss_total, head.loss);
        if (out_element_count !== head.count)
          flag_mismatch("element_count", out_element_count, head.count);
        if (out_overflow !== head.overflow)
          flag_mismatch("overflow", out_overflow, head.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] dl;
    logic              mean;
    int                sent;
    int                len;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: delta 1.0, mean on
    add_checked(16'h0000, 16'h0000, 48'd0, 17'd1, 1'b0);
    add_checked(16'h0100, 16'h0000, 48'd32768, 17'd1, 1'b0);
    add_checked(16'h7FFF, 16'h8000, 48'd16744192, 17'd1, 1'b0);
    add_checked(16'h8000, 16'h7FFF, 48'd16744192, 17'd1, 1'b0);
    // either side of the threshold
    add_pair(16'h00FF, 16'h0000, 1'b0);
    add_pair(16'hFF00, 16'h0001, 1'b0);
    add_pair(16'h0064, 16'hFF9C, 1'b1);
    add_cfg(CFG_REDUCE_MEAN, 16'h0000);
    add_pair(16'h0101, 16'h0000, 1'b0);
    add_pair(16'h0000, 16'hFF00, 1'b0);
    add_pair(16'hFFFF, 16'h0000, 1'b1);
    // zero delta: linear branch gives nothing
    add_cfg(CFG_DELTA, 16'h0000);
    add_pair(16'h0001, 16'h0000, 1'b0);
    add_pair(16'h7FFF, 16'h8000, 1'b0);
    add_checked(16'h0000, 16'h0000, 48'd0, 17'd3, 1'b0);
    add_cfg(CFG_DELTA, 16'hFFFF);
    add_checked(16'h7FFF, 16'h8000, 48'd2147418112, 17'd1, 1'b0);
    add_checked(16'h8000, 16'h7FFF, 48'd2147418112, 17'd1, 1'b0);
    add_cfg(CFG_REDUCE_MEAN, 16'h0001);
    add_pair(16'h7FFF, 16'h0000, 1'b0);
    add_pair(16'h5555, 16'hD555, 1'b0);
    add_pair(16'h8000, 16'h0001, 1'b1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].cfg_sel, dir_rows[i].pred);
      else
        send_pair(dir_rows[i].pred, dir_rows[i].target, dir_rows[i].last,
                  dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 83 : 0;
      recv_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 9 : 0;
      case (ph)
        0: begin
          dl   = 16'h0000;
          mean = 1'b0;
        end
        1: begin
          dl   = 16'hFFFF;
          mean = 1'b1;
        end
        default: begin
          dl   = ($urandom_range(1) == 0) ? 16'($urandom_range(1023)) : 16'($urandom);
          mean = 1'($urandom_range(1));
        end
      endcase
      write_reg(CFG_DELTA, dl);
      write_reg(CFG_REDUCE_MEAN, {15'd0, mean});
      // stall the output long enough for the input to back up
      if (ph == 4) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(6, 1);
        for (int j = 0; j < len && sent < PHASE_ITEMS; j++) begin
          pick_pair(p, t);
          send_pair(p, t, (j == len - 1) || (sent == PHASE_ITEMS - 1), 1'b0, '0);
          sent++;
        end
      end
    end

    wait_drained();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
